// ----- rtl/point_angle_quicksort_core_macros.svh -----
// ----------------------------------------------------------------------------
// Point angle quicksort - assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef POINT_ANGLE_QUICKSORT_CORE_MACROS_SVH
`define POINT_ANGLE_QUICKSORT_CORE_MACROS_SVH

// Condition that must hold at every clock edge.
`define PASQ_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication.
`define PASQ_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PASQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pasq_pkg.sv -----
// ----------------------------------------------------------------------------
// Point angle quicksort - package
// Request and result payload types shared by the sorter modules.
// ----------------------------------------------------------------------------
package pasq_pkg;

  localparam int KeyW     = 32;
  localparam int TagPortW = 16;

  // One incoming point
  typedef struct packed {
    logic signed [KeyW-1:0]     angle_key;
    logic        [TagPortW-1:0] point_tag;
    logic                       last_point;
  } pasq_in_t;

  // One sorted point
  typedef struct packed {
    logic signed [KeyW-1:0]     sorted_key;
    logic        [TagPortW-1:0] sorted_tag;
    logic                       last_out;
  } pasq_out_t;

  // Sequencer to output stage
  typedef struct packed {
    logic      valid;
    pasq_out_t data;
  } pasq_emit_t;

endpackage

// ----- rtl/point_angle_quicksort_core.sv -----
// ----------------------------------------------------------------------------
// Point angle quicksort - top level
// Row sorter: loads points, quicksorts them by signed key, streams them out.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i): one point per
//   request, taken whenever valid while loading. Up to MAX_POINTS points are
//   kept; further points of the row are dropped. A point with last_point set
//   ends the row and starts the sort; in_stall_o stays high until the whole
//   sorted row has been handed to the output register.
//   Result channel (out_valid_o / out_stall_i / out_data_o): the row in
//   ascending key order, last_out set on its final point. Equal keys keep the
//   order a Lomuto quicksort (last element as pivot) gives them.
//   Sort: a start step, then each range is popped from the range stack and
//   partitioned with the single key comparator; a point moved below the
//   pivot needs a second write to the one-write point memory. Output then
//   reads each point from the store before handing it on.
//   Reset empties the row and the range stack; the block is ready at once.
//   A stalled receiver holds the output register and pauses the emission.
// ----------------------------------------------------------------------------
module point_angle_quicksort_core #(
  parameter int MAX_POINTS = 64,
  parameter int TAG_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pasq_pkg::pasq_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pasq_pkg::pasq_out_t  out_data_o
);
  import pasq_pkg::*;

  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int TagW = (TAG_BITS < TagPortW) ? TAG_BITS : TagPortW;

  logic             st_we;
  logic [IdxW-1:0]  st_waddr;
  logic [KeyW-1:0]  st_wkey;
  logic [TagW-1:0]  st_wtag;
  logic [IdxW-1:0]  st_ra_addr, st_rb_addr;
  logic [KeyW-1:0]  st_ra_key, st_rb_key;
  logic [TagW-1:0]  st_ra_tag, st_rb_tag;

  logic             stk_we;
  logic [IdxW-1:0]  stk_waddr, stk_raddr;
  logic [2*IdxW-1:0] stk_wdata, stk_rdata;

  pasq_emit_t       emit;
  logic             emit_ready;
  logic             out_valid_q;
  pasq_out_t        out_q;

  pasq_store #(
    .DEPTH (MAX_POINTS),
    .IDX_W (IdxW),
    .TAG_W (TagW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (st_waddr),
    .wkey_i    (st_wkey),
    .wtag_i    (st_wtag),
    .ra_addr_i (st_ra_addr),
    .rb_addr_i (st_rb_addr),
    .ra_key_o  (st_ra_key),
    .ra_tag_o  (st_ra_tag),
    .rb_key_o  (st_rb_key),
    .rb_tag_o  (st_rb_tag)
  );

  pasq_stack #(
    .DEPTH (MAX_POINTS),
    .IDX_W (IdxW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  pasq_seq #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IdxW),
    .CNT_W      (CntW),
    .TAG_W      (TagW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .emit_o       (emit),
    .emit_ready_i (emit_ready),
    .st_we_o      (st_we),
    .st_waddr_o   (st_waddr),
    .st_wkey_o    (st_wkey),
    .st_wtag_o    (st_wtag),
    .st_ra_addr_o (st_ra_addr),
    .st_rb_addr_o (st_rb_addr),
    .st_ra_key_i  (st_ra_key),
    .st_ra_tag_i  (st_ra_tag),
    .st_rb_key_i  (st_rb_key),
    .st_rb_tag_i  (st_rb_tag),
    .stk_we_o     (stk_we),
    .stk_waddr_o  (stk_waddr),
    .stk_wdata_o  (stk_wdata),
    .stk_raddr_o  (stk_raddr),
    .stk_rdata_i  (stk_rdata)
  );

  // output register: free when empty or being taken this cycle
  assign emit_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_q <= emit.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/pasq_store.sv -----
// ----------------------------------------------------------------------------
// Point angle quicksort - point store
// Key and tag memory, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pasq_store #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6,
  parameter int TAG_W = 16
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [IDX_W-1:0]              waddr_i,
  input  logic [pasq_pkg::KeyW-1:0]     wkey_i,
  input  logic [TAG_W-1:0]              wtag_i,
  input  logic [IDX_W-1:0]              ra_addr_i,
  input  logic [IDX_W-1:0]              rb_addr_i,
  output logic [pasq_pkg::KeyW-1:0]     ra_key_o,
  output logic [TAG_W-1:0]              ra_tag_o,
  output logic [pasq_pkg::KeyW-1:0]     rb_key_o,
  output logic [TAG_W-1:0]              rb_tag_o
);
  import pasq_pkg::*;

  logic [KeyW-1:0]  key_mem [DEPTH];
  logic [TAG_W-1:0] tag_mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      tag_mem[waddr_i] <= wtag_i;
    end
  end

  // two registered read ports, old data on a same-address write
  always_ff @(posedge clk_i) begin
    ra_key_o <= key_mem[ra_addr_i];
    ra_tag_o <= tag_mem[ra_addr_i];
    rb_key_o <= key_mem[rb_addr_i];
    rb_tag_o <= tag_mem[rb_addr_i];
  end

endmodule

// ----- rtl/pasq_stack.sv -----
// ----------------------------------------------------------------------------
// Point angle quicksort - range stack
// Memory of pending sort ranges {lo, hi}, one write and one registered read.
// ----------------------------------------------------------------------------
module pasq_stack #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IDX_W-1:0]     waddr_i,
  input  logic [2*IDX_W-1:0]   wdata_i,
  input  logic [IDX_W-1:0]     raddr_i,
  output logic [2*IDX_W-1:0]   rdata_o
);

  logic [2*IDX_W-1:0] range_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      range_mem[waddr_i] <= wdata_i;
    end
    rdata_o <= range_mem[raddr_i];
  end

endmodule

// ----- rtl/pasq_seq.sv -----
// ----------------------------------------------------------------------------
// Point angle quicksort - sequencer
// Loads a row, runs Lomuto partitions off the range stack with one shared
// key comparator, then streams the sorted row to the output stage.
// ----------------------------------------------------------------------------
`include "point_angle_quicksort_core_macros.svh"

module pasq_seq #(
  parameter int MAX_POINTS = 64,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7,
  parameter int TAG_W      = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  input  pasq_pkg::pasq_in_t            in_data_i,
  output logic                          in_stall_o,
  // to output stage
  output pasq_pkg::pasq_emit_t          emit_o,
  input  logic                          emit_ready_i,
  // point store
  output logic                          st_we_o,
  output logic [IDX_W-1:0]              st_waddr_o,
  output logic [pasq_pkg::KeyW-1:0]     st_wkey_o,
  output logic [TAG_W-1:0]              st_wtag_o,
  output logic [IDX_W-1:0]              st_ra_addr_o,
  output logic [IDX_W-1:0]              st_rb_addr_o,
  input  logic [pasq_pkg::KeyW-1:0]     st_ra_key_i,
  input  logic [TAG_W-1:0]              st_ra_tag_i,
  input  logic [pasq_pkg::KeyW-1:0]     st_rb_key_i,
  input  logic [TAG_W-1:0]              st_rb_tag_i,
  // range stack
  output logic                          stk_we_o,
  output logic [IDX_W-1:0]              stk_waddr_o,
  output logic [2*IDX_W-1:0]            stk_wdata_o,
  output logic [IDX_W-1:0]              stk_raddr_o,
  input  logic [2*IDX_W-1:0]            stk_rdata_i
);
  import pasq_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_PIV   = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_SWAP  = 4'd7;
  localparam logic [3:0] S_FIN1  = 4'd8;
  localparam logic [3:0] S_FIN2  = 4'd9;
  localparam logic [3:0] S_PUSH  = 4'd10;
  localparam logic [3:0] S_ERD   = 4'd11;
  localparam logic [3:0] S_ELD   = 4'd12;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] sp_q, sp_d;
  logic [IDX_W-1:0] lo_q, lo_d;
  logic [IDX_W-1:0] hi_q, hi_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] next_q, next_d;
  logic [KeyW-1:0]  pivot_q, pivot_d;

  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] sp_m1;
  logic [IDX_W-1:0] pop_lo, pop_hi;
  logic             key_lt;
  logic             last_elem;

  assign cnt_m1    = count_q - 1'b1;
  assign sp_m1     = sp_q - 1'b1;
  assign pop_lo    = stk_rdata_i[2*IDX_W-1:IDX_W];
  assign pop_hi    = stk_rdata_i[IDX_W-1:0];
  // the shared comparator: scanned key strictly below pivot
  assign key_lt    = $signed(st_ra_key_i) < $signed(pivot_q);
  assign last_elem = (CNT_W'(j_q) == cnt_m1);

  assign in_stall_o = (state_q != S_LOAD);

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    sp_d     = sp_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    j_d      = j_q;
    next_d   = next_q;
    pivot_d  = pivot_q;

    st_we_o      = 1'b0;
    st_waddr_o   = next_q;
    st_wkey_o    = st_ra_key_i;
    st_wtag_o    = st_ra_tag_i;
    st_ra_addr_o = j_q;
    st_rb_addr_o = next_q;

    stk_we_o     = 1'b0;
    stk_waddr_o  = sp_q[IDX_W-1:0];
    stk_wdata_o  = {lo_q, hi_q};
    stk_raddr_o  = sp_m1[IDX_W-1:0];

    emit_o.valid           = 1'b0;
    emit_o.data.sorted_key = st_ra_key_i;
    emit_o.data.sorted_tag = TagPortW'(st_ra_tag_i);
    emit_o.data.last_out   = last_elem;

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          // points past a full store are dropped
          if (count_q < CNT_W'(MAX_POINTS)) begin
            st_we_o    = 1'b1;
            st_waddr_o = count_q[IDX_W-1:0];
            st_wkey_o  = in_data_i.angle_key;
            st_wtag_o  = in_data_i.point_tag[TAG_W-1:0];
            count_d    = count_q + 1'b1;
          end
          if (in_data_i.last_point) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        j_d = '0;
        if (count_q < CNT_W'(2)) begin
          state_d = S_ERD;
        end else begin
          stk_we_o    = 1'b1;
          stk_waddr_o = '0;
          stk_wdata_o = {IDX_W'(0), cnt_m1[IDX_W-1:0]};
          sp_d        = CNT_W'(1);
          state_d     = S_POP;
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          j_d     = '0;
          state_d = S_ERD;
        end else begin
          sp_d    = sp_m1;
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        lo_d         = pop_lo;
        hi_d         = pop_hi;
        st_ra_addr_o = pop_hi;
        // degenerate or stale range: skip it
        if ((CNT_W'(pop_hi) >= count_q) || (pop_lo >= pop_hi)) begin
          state_d = S_POP;
        end else begin
          state_d = S_PIV;
        end
      end
      S_PIV: begin
        pivot_d = st_ra_key_i;
        j_d     = lo_q;
        next_d  = lo_q;
        state_d = S_RD;
      end
      S_RD: begin
        // ra reads j, rb reads next
        if (j_q == hi_q) begin
          state_d = S_FIN1;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (key_lt) begin
          // first half of swap: next <- j
          st_we_o    = 1'b1;
          st_waddr_o = next_q;
          state_d    = S_SWAP;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_SWAP: begin
        st_we_o    = 1'b1;
        st_waddr_o = j_q;
        st_wkey_o  = st_rb_key_i;
        st_wtag_o  = st_rb_tag_i;
        next_d     = next_q + 1'b1;
        j_d        = j_q + 1'b1;
        state_d    = S_RD;
      end
      S_FIN1: begin
        // pivot into its slot
        st_we_o    = 1'b1;
        st_waddr_o = next_q;
        state_d    = S_FIN2;
      end
      S_FIN2: begin
        st_we_o    = 1'b1;
        st_waddr_o = hi_q;
        st_wkey_o  = st_rb_key_i;
        st_wtag_o  = st_rb_tag_i;
        // right part first, so the left part is popped first
        if ((CNT_W'(next_q) + 1'b1) < CNT_W'(hi_q)) begin
          stk_we_o    = 1'b1;
          stk_wdata_o = {next_q + 1'b1, hi_q};
          sp_d        = sp_q + 1'b1;
        end
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (CNT_W'(next_q) > (CNT_W'(lo_q) + 1'b1)) begin
          stk_we_o    = 1'b1;
          stk_wdata_o = {lo_q, next_q - 1'b1};
          sp_d        = sp_q + 1'b1;
        end
        state_d = S_POP;
      end
      S_ERD: begin
        state_d = S_ELD;
      end
      S_ELD: begin
        if (emit_ready_i) begin
          emit_o.valid = 1'b1;
          if (last_elem) begin
            count_d = '0;
            sp_d    = '0;
            state_d = S_LOAD;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sp_q    <= sp_d;
    end
  end

  // working indexes and pivot
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    j_q     <= j_d;
    next_q  <= next_d;
    pivot_q <= pivot_d;
  end

  // checks
  `PASQ_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_POINTS), "row count over store depth")
  `PASQ_ASSERT(a_stack_bound, sp_q <= CNT_W'(MAX_POINTS), "range stack overflow")
  `PASQ_ASSERT_IMPL(a_scan_order,
      (state_q == S_RD) || (state_q == S_CMP) || (state_q == S_SWAP),
      (next_q <= j_q) && (j_q <= hi_q) && (lo_q <= next_q), "partition indexes out of order")
  `PASQ_ASSERT_IMPL(a_range_ok, state_q == S_PIV,
      (lo_q < hi_q) && (CNT_W'(hi_q) < count_q), "partition range outside row")
  `PASQ_ASSERT_NEXT(a_last_starts, in_valid_i && !in_stall_o && in_data_i.last_point,
      state_q == S_START, "last point did not start sort")

endmodule
